FILE: rtl/b64d_pkg.sv
// Shared types and the character classifier for the base64 stream decoder.
// Used by every module of the decoder; depends on nothing.
package b64d_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       bad_char;
    logic       message_end;
    logic       run_end;
  } out_word_t;

  typedef enum logic [1:0] {
    ClsSym,
    ClsSpace,
    ClsPad,
    ClsBad
  } cls_kind_e;

  typedef struct packed {
    cls_kind_e  kind;
    logic [5:0] value;
  } cls_t;

  // One decoded run: up to three results sharing flags; bytes MSB first.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  last_idx;
    logic        has_byte;
    logic        bad_char;
    logic        message_end;
  } job_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.kind  = ClsBad;
    r.value = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.kind  = ClsSym;
      r.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.kind  = ClsSym;
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.kind  = ClsSym;
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.kind  = ClsSym;
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.kind  = ClsSym;
      r.value = 6'd63;
    end else if (c inside {8'h09, 8'h0A, 8'h0D}) begin
      r.kind = ClsSpace;
    end else if (c == 8'h3D) begin
      r.kind = ClsPad;
    end
    return r;
  endfunction

endpackage

FILE: rtl/b64d_front.sv
// Front end: classifies each character, keeps the symbol accumulator and
// message state, and emits one run descriptor per word that yields results. Uses b64d_pkg.
module b64d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  b64d_pkg::in_word_t  in_word_i,
  output logic                job_vld_o,
  output b64d_pkg::job_t      job_o
);

  logic [17:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pad_q, pad_d;
  logic        err_q, err_d;

  b64d_pkg::cls_t cls;
  b64d_pkg::job_t job;
  logic           job_vld;
  logic [17:0]    acc2;
  logic [1:0]     cnt2;
  logic           pad2, err2;

  always_comb begin
    cls     = b64d_pkg::classify(in_word_i.char_code);
    acc2    = acc_q;
    cnt2    = cnt_q;
    pad2    = pad_q;
    err2    = err_q;
    job     = '0;
    job_vld = 1'b0;

    if (!pad_q && !err_q) begin
      case (cls.kind)
        b64d_pkg::ClsBad: begin
          err2         = 1'b1;
          job_vld      = 1'b1;
          job.bad_char = 1'b1;
        end
        b64d_pkg::ClsPad: begin
          pad2 = 1'b1;
        end
        b64d_pkg::ClsSym: begin
          if (cnt_q == 2'd3) begin
            job_vld      = 1'b1;
            job.bytes    = {acc_q, cls.value};
            job.has_byte = 1'b1;
            job.last_idx = 2'd2;
            acc2         = '0;
            cnt2         = 2'd0;
          end else begin
            acc2 = {acc_q[11:0], cls.value};
            cnt2 = cnt_q + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // flush on the last character unless a run was already produced
    if (in_word_i.is_final && !job_vld) begin
      job_vld = 1'b1;
      if (!err2 && cnt2 == 2'd3) begin
        job.bytes    = {acc2[17:10], acc2[9:2], 8'h00};
        job.has_byte = 1'b1;
        job.last_idx = 2'd1;
      end else if (!err2 && cnt2 == 2'd2) begin
        job.bytes    = {acc2[11:4], 16'h0000};
        job.has_byte = 1'b1;
      end else begin
        job.bad_char = err2;
      end
    end
    job.message_end = in_word_i.is_final;

    if (in_word_i.is_final) begin
      acc_d = '0;
      cnt_d = 2'd0;
      pad_d = 1'b0;
      err_d = 1'b0;
    end else begin
      acc_d = acc2;
      cnt_d = cnt2;
      pad_d = pad2;
      err_d = err2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= 2'd0;
      pad_q <= 1'b0;
      err_q <= 1'b0;
    end else if (accept_i) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      pad_q <= pad_d;
      err_q <= err_d;
    end
  end

  assign job_vld_o = accept_i && job_vld;
  assign job_o     = job;

endmodule

FILE: rtl/b64d_queue.sv
// Small FIFO of run descriptors between front and back end.
// Uses b64d_pkg for the descriptor type.
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  b64d_pkg::job_t wr_data_i,
  input  logic           rd_i,
  output b64d_pkg::job_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  b64d_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  logic do_wr, do_rd;

  assign full_o    = (cnt_q == DepthCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64d_back.sv
// Back end: walks the head run descriptor into an output register, one result
// per cycle while that register is empty or being popped. Uses b64d_pkg.
module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::job_t      job_i,
  input  logic                job_empty_i,
  output logic                job_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output b64d_pkg::out_word_t out_word_o
);

  b64d_pkg::out_word_t out_q, out_d;
  logic                vld_q;
  logic [1:0]          idx_q;
  logic                adv, last;
  logic [7:0]          sel_byte;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = job_i.bytes[23:16];
      2'd1:    sel_byte = job_i.bytes[15:8];
      default: sel_byte = job_i.bytes[7:0];
    endcase
  end

  assign adv       = !vld_q || pop_i;
  assign last      = (idx_q == job_i.last_idx);
  assign job_pop_o = adv && !job_empty_i && last;

  always_comb begin
    out_d.data_byte   = sel_byte;
    out_d.has_byte    = job_i.has_byte;
    out_d.bad_char    = job_i.bad_char;
    out_d.message_end = job_i.message_end && last;
    out_d.run_end     = last;
  end

  always_ff @(posedge clk_i) begin
    if (adv && !job_empty_i) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (adv) begin
      vld_q <= !job_empty_i;
      if (!job_empty_i) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  assign empty_o    = !vld_q;
  assign out_word_o = out_q;

endmodule

FILE: rtl/base64_stream_decoder_unit.sv
// Base64 stream decoder: one character word in per cycle while not full, decoded words out.
// Path: a character's run descriptor is queued in the FIFO, then its results are registered.
// Throughput: one character per cycle in while not full, one result per
// cycle out while popped; a full quad makes three results, walked out in turn,
// with a descriptor FIFO between classifier and serializer absorbing the burst.
// Reset (rst_ni low, async) clears decode state, FIFO and output valid.
module base64_stream_decoder_unit #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64d_pkg::in_word_t  in_word_i,
  output logic                empty,
  input  logic                pop,
  output b64d_pkg::out_word_t out_word_o
);

  logic           accept;
  logic           job_wr, job_rd, job_empty;
  b64d_pkg::job_t job_in, job_head;

  assign accept = push && !full;

  b64d_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .job_vld_o (job_wr),
    .job_o     (job_in)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_wr),
    .wr_data_i (job_in),
    .rd_i      (job_rd),
    .rd_data_o (job_head),
    .full_o    (full),
    .empty_o   (job_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: dv/base64_stream_decoder_unit_checker.sv
// Checker for the base64 stream decoder: watches both queue-style ports,
// predicts the decoded words from the accepted characters and compares them.
// Depends on b64d_pkg for the word types and the character class enum.
module base64_stream_decoder_unit_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  b64d_pkg::in_word_t  in_word_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  b64d_pkg::out_word_t out_word_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  chars_taken_o,
  output int                  words_checked_o
);

  // decoder state as seen from outside
  logic [17:0] sym_accum = '0;
  logic [1:0]  sym_count = '0;
  logic        pad_seen  = 1'b0;
  logic        err_seen  = 1'b0;

  b64d_pkg::out_word_t decoded_words[$];
  int                  fails         = 0;
  int                  chars_taken   = 0;
  int                  words_checked = 0;
  int                  pending       = 0;

  assign fail_count_o    = fails;
  assign pending_o       = pending;
  assign chars_taken_o   = chars_taken;
  assign words_checked_o = words_checked;

  function automatic b64d_pkg::cls_t sort_char(input logic [7:0] c);
    b64d_pkg::cls_t r;
    r.kind  = b64d_pkg::ClsBad;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.kind  = b64d_pkg::ClsSym;
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.kind  = b64d_pkg::ClsSym;
      r.value = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind  = b64d_pkg::ClsSym;
      r.value = 6'(c + 8'h04);
    end else if (c == 8'h2B) begin
      r.kind  = b64d_pkg::ClsSym;
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.kind  = b64d_pkg::ClsSym;
      r.value = 6'd63;
    end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
      r.kind = b64d_pkg::ClsSpace;
    end else if (c == 8'h3D) begin
      r.kind = b64d_pkg::ClsPad;
    end
    return r;
  endfunction

  function automatic b64d_pkg::out_word_t make_word(input logic [7:0] b, input logic has,
                                                    input logic bad);
    b64d_pkg::out_word_t w;
    w.data_byte   = b;
    w.has_byte    = has;
    w.bad_char    = bad;
    w.message_end = 1'b0;
    w.run_end     = 1'b0;
    return w;
  endfunction

  task automatic decode_char(input b64d_pkg::in_word_t w);
    b64d_pkg::cls_t      cls;
    logic [23:0]         quad;
    b64d_pkg::out_word_t run[$];
    int                  last;
    if (!pad_seen && !err_seen) begin
      cls = sort_char(w.char_code);
      case (cls.kind)
        b64d_pkg::ClsBad: begin
          err_seen = 1'b1;
          run.push_back(make_word(8'h00, 1'b0, 1'b1));
        end
        b64d_pkg::ClsPad: pad_seen = 1'b1;
        b64d_pkg::ClsSym: begin
          if (sym_count == 2'd3) begin
            quad = {sym_accum, cls.value};
            run.push_back(make_word(quad[23:16], 1'b1, 1'b0));
            run.push_back(make_word(quad[15:8], 1'b1, 1'b0));
            run.push_back(make_word(quad[7:0], 1'b1, 1'b0));
            sym_accum = '0;
            sym_count = '0;
          end else begin
            sym_accum = {sym_accum[11:0], cls.value};
            sym_count = sym_count + 2'd1;
          end
        end
        default: ;
      endcase
    end
    if (w.is_final) begin
      // flush: three pending symbols give two bytes, two give one
      if (!err_seen) begin
        if (sym_count == 2'd3) begin
          run.push_back(make_word(sym_accum[17:10], 1'b1, 1'b0));
          run.push_back(make_word(sym_accum[9:2], 1'b1, 1'b0));
        end else if (sym_count == 2'd2) begin
          run.push_back(make_word(sym_accum[11:4], 1'b1, 1'b0));
        end
      end
      if (run.size() == 0) run.push_back(make_word(8'h00, 1'b0, err_seen));
      last = run.size() - 1;
      run[last].message_end = 1'b1;
      sym_accum = '0;
      sym_count = '0;
      pad_seen  = 1'b0;
      err_seen  = 1'b0;
    end
    if (run.size() > 0) begin
      last = run.size() - 1;
      run[last].run_end = 1'b1;
    end
    foreach (run[i]) decoded_words.push_back(run[i]);
  endtask

  task automatic check_word(input b64d_pkg::out_word_t got);
    b64d_pkg::out_word_t want;
    if (decoded_words.size() == 0) begin
      $error("unexpected result word %h", got);
      fails++;
      return;
    end
    want = decoded_words.pop_front();
    words_checked++;
    if (got.data_byte !== want.data_byte) begin
      $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
      fails++;
    end
    if (got.has_byte !== want.has_byte) begin
      $error("has_byte: expected %b, got %b", want.has_byte, got.has_byte);
      fails++;
    end
    if (got.bad_char !== want.bad_char) begin
      $error("bad_char: expected %b, got %b", want.bad_char, got.bad_char);
      fails++;
    end
    if (got.message_end !== want.message_end) begin
      $error("message_end: expected %b, got %b", want.message_end, got.message_end);
      fails++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %b, got %b", want.run_end, got.run_end);
      fails++;
    end
  endtask

  // results pass through the FIFO and the output register, so they trail their
  // character and checking the output before predicting from the input is safe
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_i) check_word(out_word_i);
      if (push_i && !full_i) begin
        decode_char(in_word_i);
        chars_taken++;
      end
      pending = decoded_words.size();
    end
  end

endmodule

FILE: dv/base64_stream_decoder_unit_test.sv
// Testbench top for the base64 stream decoder: clock, reset, character
// stimulus and back-pressure; checking is done by the checker module.
// Depends on b64d_pkg, base64_stream_decoder_unit and its checker.
module base64_stream_decoder_unit_test;

  localparam int ClkPeriod = 8;
  localparam int RandItems = 410;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  b64d_pkg::in_word_t  in_word_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  b64d_pkg::out_word_t out_word_o;

  int fail_count;
  int pending;
  int chars_taken;
  int words_checked;

  int send_idle_pct = 12;
  int recv_idle_pct = 78;
  int chars_sent = 0;
  int messages = 0;

  base64_stream_decoder_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  base64_stream_decoder_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .in_word_i       (in_word_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_word_i      (out_word_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .chars_taken_o   (chars_taken),
    .words_checked_o (words_checked)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push                <= 1'b1;
    in_word_i.char_code <= c;
    in_word_i.is_final  <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    chars_sent++;
    if (fin) messages++;
  endtask

  function automatic logic [7:0] sym_char(input int v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 2))
      0: return 8'h09;
      1: return 8'h0A;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] bad_char_code();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(0, 8));
      2: return 8'($urandom_range(8'h20, 8'h2A));
      default: return 8'($urandom_range(8'h7B, 8'h7F));
    endcase
  endfunction

  // mostly well-formed messages; some broken by a bad character, some noise,
  // some with junk after the padding
  task automatic send_message();
    logic [7:0] chars[$];
    int         kind;
    int         n;
    int         pos;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(0, 10);
    if (kind == 8) begin
      for (int i = 0; i <= n; i++) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < n; i++) begin
        chars.push_back(sym_char($urandom_range(0, 63)));
        if ($urandom_range(0, 7) == 0) chars.push_back(space_char());
      end
      if (kind <= 6 && (n % 4) != 0 && $urandom_range(0, 1) == 1) begin
        for (int i = n % 4; i < 4; i++) chars.push_back(8'h3D);
      end
      if (kind == 7) begin
        pos = $urandom_range(0, chars.size());
        chars.insert(pos, bad_char_code());
        if ($urandom_range(0, 1) == 1) chars.push_back(bad_char_code());
      end
      if (kind == 9) begin
        chars.push_back(8'h3D);
        for (int i = 0; i < $urandom_range(1, 4); i++)
          chars.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (chars.size() == 0) chars.push_back(space_char());
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // full quads, alphabet edges
    send_char(8'h54, 1'b0);
    send_char(8'h57, 1'b0);
    send_char(8'h46, 1'b0);
    send_char(8'h75, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h5A, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h7A, 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h39, 1'b0);
    send_char(8'h2B, 1'b0);
    send_char(8'h2F, 1'b1);
    // whitespace only, final on whitespace
    send_char(8'h09, 1'b0);
    send_char(8'h0A, 1'b0);
    send_char(8'h0D, 1'b1);
    // padding, then junk that is ignored, flush of two symbols
    send_char(8'h51, 1'b0);
    send_char(8'h51, 1'b0);
    send_char(8'h3D, 1'b0);
    send_char(8'hFF, 1'b1);
    // single pending symbol dropped
    send_char(8'h41, 1'b1);
    // bad character, second bad ignored, aborted end
    send_char(8'h80, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h42, 1'b1);
    // bad character as the final one
    send_char(8'h00, 1'b1);
    // unpadded three-symbol flush
    send_char(8'h41, 1'b0);
    send_char(8'h42, 1'b0);
    send_char(8'h43, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 12; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (chars_sent < 27 + (phase + 1) * RandItems / 3) send_message();
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d characters in %0d messages under three back-pressure mixes",
             chars_taken, messages);
    $display("Checked %0d decoded words, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(ClkPeriod * 300000);
    $display("Timed out with %0d words still expected", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
